// ===== rtl/core/rlas_pkg.sv =====
// Package for the rule linkage action sequencer: item structs, stored entry
// layouts, function and phase codes, and the sequencer state type.
// No dependencies.
package rlas_pkg;

   localparam int MAX_ACTS = 4;

   localparam logic [1:0] FUNC_EVAL = 2'd0;
   localparam logic [1:0] FUNC_HDR  = 2'd1;
   localparam logic [1:0] FUNC_ACT  = 2'd2;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_EXEC = 2'd1;
   localparam logic [1:0] PH_DONE = 2'd2;

   typedef struct packed {
      logic [1:0] func;
      logic [5:0] rule_index;
      logic       cond_ok;
      logic       exec_permit;
      logic       rule_active;
      logic       stop_mode;
      logic [2:0] num_actions;
      logic [1:0] action_slot;
      logic [7:0] loop_no;
      logic [7:0] dev_no;
      logic [7:0] channel;
      logic       start_bit;
   } req_type;

   typedef struct packed {
      logic [5:0] out_rule;
      logic [7:0] out_loop;
      logic [7:0] out_dev;
      logic [7:0] out_channel;
      logic       out_start;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic                active;
      logic                stop;
      logic [2:0]          count;
      logic [1:0]          phase;
      logic [MAX_ACTS-1:0] done;
   } rule_entry_type;

   typedef struct packed {
      logic       start;
      logic [7:0] channel;
      logic [7:0] dev;
      logic [7:0] loop_no;
   } action_entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RULE,
      S_READ,
      S_WAIT,
      S_MASK,
      S_EMIT
   } state_type;

endpackage

// ===== rtl/core/rule_linkage_action_sequencer.sv =====
// Rule linkage action sequencer: rule memory with per-entry valid bits,
// action memory, phase update and command emission.
// Depends on rlas_pkg.
//
//   port group   direction  handshake            payload
//   req_*        in         req_valid/req_stall  rlas_pkg::req_type
//   rsp_*        out        rsp_valid/rsp_stall  rlas_pkg::rsp_type
//
// Header and action writes and evaluate items that read no action use only the
// rule state; others pass read, wait, mask and, if commands are due, emit:
// the action memory gives one entry per cycle, commands one per unstalled cycle.
// Reset clears all rule headers, phases and done flags at once (valid bits).
// A stalled response holds in the output register; the next item is taken
// while the last command still waits.
module rule_linkage_action_sequencer #(
   parameter int RULE_SLOTS       = 64,
   parameter int ACTIONS_PER_RULE = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rlas_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rlas_pkg::rsp_type rsp_item
);

   localparam int ACT_SLOTS = (ACTIONS_PER_RULE < rlas_pkg::MAX_ACTS) ?
                              ACTIONS_PER_RULE : rlas_pkg::MAX_ACTS;
   localparam int ACT_DEPTH = RULE_SLOTS * ACTIONS_PER_RULE;
   localparam int RW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int AW = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;

   rlas_pkg::rule_entry_type   rule_mem [RULE_SLOTS];
   rlas_pkg::action_entry_type act_mem  [ACT_DEPTH];

   rlas_pkg::state_type        state_ff, state_in;
   rlas_pkg::req_type          item_ff;
   logic [RULE_SLOTS-1:0]      valid_ff;
   logic                       rvalid_ff;
   rlas_pkg::rule_entry_type   rule_q_ff;
   rlas_pkg::action_entry_type act_q_ff;
   logic [2:0]                 cnt_ff;
   logic                       stop_ff;
   logic                       idle_br_ff;
   logic [rlas_pkg::MAX_ACTS-1:0] done_ff;
   logic [2:0]                 j_ff;
   logic                       rd_pend_ff;
   logic [1:0]                 rd_slot_ff;
   rlas_pkg::action_entry_type lane_ff [rlas_pkg::MAX_ACTS];
   logic [rlas_pkg::MAX_ACTS-1:0] mask_ff, mask_in;
   logic                       rsp_valid_ff;
   rlas_pkg::rsp_type          rsp_ff, rsp_in;

   rlas_pkg::rule_entry_type   entry, new_entry;
   logic                       in_range, rule_we, act_we, act_re, go_emit, idle_br;
   logic [RW-1:0]              raddr, waddr;
   logic [AW-1:0]              abase, act_raddr, act_waddr;
   logic [2:0]                 cnt_sat;
   logic [1:0]                 sel;
   logic [rlas_pkg::MAX_ACTS-1:0] rest;
   logic                       load;
   rlas_pkg::action_entry_type act_wdata;

   function automatic logic [rlas_pkg::MAX_ACTS-1:0] low_mask(input logic [2:0] n);
      logic [rlas_pkg::MAX_ACTS-1:0] m;
      for (int k = 0; k < rlas_pkg::MAX_ACTS; k++) begin
         m[k] = (k < int'(n));
      end
      return m;
   endfunction

   assign raddr     = RW'(req_item.rule_index);
   assign waddr     = RW'(item_ff.rule_index);
   assign in_range  = int'(item_ff.rule_index) < RULE_SLOTS;
   assign entry     = rvalid_ff ? rule_q_ff : '0;
   assign abase     = AW'(int'(item_ff.rule_index) * ACTIONS_PER_RULE);
   assign act_raddr = abase + AW'(j_ff);
   assign act_waddr = abase + AW'(item_ff.action_slot);
   assign cnt_sat   = (int'(item_ff.num_actions) > ACT_SLOTS) ?
                      3'(ACT_SLOTS) : item_ff.num_actions;
   assign act_wdata = '{start: item_ff.start_bit, channel: item_ff.channel,
                        dev: item_ff.dev_no, loop_no: item_ff.loop_no};

   // rule update
   always_comb begin
      new_entry = entry;
      rule_we   = 1'b0;
      act_we    = 1'b0;
      go_emit   = 1'b0;
      idle_br   = 1'b0;
      if (state_ff == rlas_pkg::S_RULE && in_range) begin
         case (item_ff.func)
            rlas_pkg::FUNC_HDR: begin
               rule_we         = 1'b1;
               new_entry.active = item_ff.rule_active;
               new_entry.stop  = item_ff.stop_mode;
               new_entry.count = cnt_sat;
            end
            rlas_pkg::FUNC_ACT: begin
               act_we = int'(item_ff.action_slot) < ACT_SLOTS;
            end
            rlas_pkg::FUNC_EVAL: begin
               if (entry.active) begin
                  rule_we = 1'b1;
                  case (entry.phase)
                     rlas_pkg::PH_IDLE: begin
                        if (item_ff.cond_ok && item_ff.exec_permit) begin
                           new_entry.phase = rlas_pkg::PH_EXEC;
                           new_entry.done  = entry.done | low_mask(entry.count);
                           go_emit         = entry.count != 3'd0;
                           idle_br         = 1'b1;
                        end
                     end
                     rlas_pkg::PH_EXEC: begin
                        if (!item_ff.cond_ok) begin
                           new_entry.phase = rlas_pkg::PH_DONE;
                           go_emit         = entry.count != 3'd0;
                        end
                     end
                     default: begin
                        new_entry.phase = rlas_pkg::PH_IDLE;
                        new_entry.done  = '0;
                     end
                  endcase
               end
            end
            default: begin
            end
         endcase
      end
   end

   // command selection
   always_comb begin
      for (int k = 0; k < rlas_pkg::MAX_ACTS; k++) begin
         mask_in[k] = (k < int'(cnt_ff)) &&
                      (idle_br_ff || (done_ff[k] && !stop_ff && lane_ff[k].start));
      end
      sel = 2'd0;
      for (int k = rlas_pkg::MAX_ACTS - 1; k >= 0; k--) begin
         if (mask_ff[k]) begin
            sel = 2'(k);
         end
      end
      rest = mask_ff & ~(rlas_pkg::MAX_ACTS'(1) << sel);
      rsp_in.out_rule    = item_ff.rule_index;
      rsp_in.out_loop    = lane_ff[sel].loop_no;
      rsp_in.out_dev     = lane_ff[sel].dev;
      rsp_in.out_channel = lane_ff[sel].channel;
      rsp_in.out_start   = idle_br_ff && !stop_ff && lane_ff[sel].start;
      rsp_in.last        = rest == '0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rlas_pkg::S_IDLE: if (req_valid) state_in = rlas_pkg::S_RULE;
         rlas_pkg::S_RULE: state_in = go_emit ? rlas_pkg::S_READ : rlas_pkg::S_IDLE;
         rlas_pkg::S_READ: begin
            if ((j_ff + 3'd1) == cnt_ff) state_in = rlas_pkg::S_WAIT;
         end
         rlas_pkg::S_WAIT: state_in = rlas_pkg::S_MASK;
         rlas_pkg::S_MASK: state_in = (mask_in != '0) ? rlas_pkg::S_EMIT : rlas_pkg::S_IDLE;
         rlas_pkg::S_EMIT: if (load && rest == '0) state_in = rlas_pkg::S_IDLE;
         default: state_in = rlas_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = state_ff != rlas_pkg::S_IDLE;
      act_re    = state_ff == rlas_pkg::S_READ;
      load      = (state_ff == rlas_pkg::S_EMIT) && (!rsp_valid_ff || !rsp_stall);
      rsp_valid = rsp_valid_ff;
      rsp_item  = rsp_ff;
   end

   // memories
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         rule_q_ff <= rule_mem[raddr];
      end
      if (rule_we) begin
         rule_mem[waddr] <= new_entry;
      end
      if (act_re) begin
         act_q_ff <= act_mem[act_raddr];
      end
      if (act_we) begin
         act_mem[act_waddr] <= act_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlas_pkg::S_IDLE;
         valid_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= act_re;
         if (rule_we) begin
            valid_ff[waddr] <= 1'b1;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff   <= req_item;
         rvalid_ff <= valid_ff[raddr];
      end
      if (state_ff == rlas_pkg::S_RULE) begin
         cnt_ff     <= entry.count;
         stop_ff    <= entry.stop;
         idle_br_ff <= idle_br;
         done_ff    <= entry.done;
         j_ff       <= 3'd0;
      end else if (act_re) begin
         j_ff <= j_ff + 3'd1;
      end
      rd_slot_ff <= j_ff[1:0];
      if (rd_pend_ff) begin
         lane_ff[rd_slot_ff] <= act_q_ff;
      end
      if (state_ff == rlas_pkg::S_MASK) begin
         mask_ff <= mask_in;
      end else if (load) begin
         mask_ff <= rest;
      end
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   a_accept_to_rule: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == rlas_pkg::S_RULE)
      else $error("accepted item did not enter rule stage");

   a_emit_has_work: assert property (@(posedge clock) disable iff (reset)
      state_ff == rlas_pkg::S_EMIT |-> mask_ff != '0)
      else $error("emit stage with empty command mask");

   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == rlas_pkg::S_READ |-> j_ff < cnt_ff && cnt_ff <= 3'(ACT_SLOTS))
      else $error("action read beyond rule count");

   a_inactive_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == rlas_pkg::S_RULE && !entry.active |=> state_ff == rlas_pkg::S_IDLE)
      else $error("inactive rule started a command sequence");

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the rule linkage action sequencer: random and directed rule, action and
// evaluate items, with a scoreboard class that predicts the device commands and checks them.
// Depends on rlas_pkg and rule_linkage_action_sequencer.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rlas_pkg::*;

   localparam int RULES = 64;
   localparam int ACTS = 4;
   localparam logic [1:0] FUNC_NONE = 2'd3;
   localparam int RANDOM_ITEMS = 420;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 40;

   class cmd_scoreboard;
      bit                  rule_on[RULES];
      bit                  rule_stop[RULES];
      bit [2:0]            rule_count[RULES];
      bit [1:0]            rule_phase[RULES];
      bit [MAX_ACTS-1:0]   rule_done[RULES];
      action_entry_type    actions[RULES*ACTS];
      bit                  written[RULES*ACTS];
      rsp_type             expected_cmds[$];
      int                  errors;

      function rsp_type make_cmd(int r, action_entry_type a, bit start);
         rsp_type c;
         c.out_rule = r[5:0];
         c.out_loop = a.loop_no;
         c.out_dev = a.dev;
         c.out_channel = a.channel;
         c.out_start = start;
         c.last = 1'b0;
         return c;
      endfunction

      function void apply_item(req_type it);
         int       r;
         int       n;
         int       idx;
         bit [2:0] cnt;
         rsp_type  cmds[MAX_ACTS];
         r = it.rule_index;
         n = 0;
         case (it.func)
            FUNC_HDR: begin
               cnt = (it.num_actions > MAX_ACTS) ? 3'(MAX_ACTS) : it.num_actions;
               rule_on[r] = it.rule_active;
               rule_stop[r] = it.stop_mode;
               rule_count[r] = cnt;
            end
            FUNC_ACT: begin
               idx = r * ACTS + it.action_slot;
               actions[idx].start = it.start_bit;
               actions[idx].channel = it.channel;
               actions[idx].dev = it.dev_no;
               actions[idx].loop_no = it.loop_no;
               written[idx] = 1'b1;
            end
            FUNC_EVAL: if (rule_on[r]) begin
               case (rule_phase[r])
                  PH_IDLE: if (it.cond_ok && it.exec_permit) begin
                     for (int j = 0; j < rule_count[r]; j++) begin
                        cmds[n] = make_cmd(r, actions[r*ACTS+j],
                                           rule_stop[r] ? 1'b0 : actions[r*ACTS+j].start);
                        n++;
                        rule_done[r][j] = 1'b1;
                     end
                     rule_phase[r] = PH_EXEC;
                  end
                  PH_EXEC: if (!it.cond_ok) begin
                     for (int j = 0; j < rule_count[r]; j++) begin
                        if (rule_done[r][j] && !rule_stop[r] && actions[r*ACTS+j].start) begin
                           cmds[n] = make_cmd(r, actions[r*ACTS+j], 1'b0);
                           n++;
                        end
                     end
                     rule_phase[r] = PH_DONE;
                  end
                  default: begin
                     rule_done[r] = '0;
                     rule_phase[r] = PH_IDLE;
                  end
               endcase
            end
            default: ;
         endcase
         for (int k = 0; k < n; k++) begin
            cmds[k].last = (k == n - 1);
            expected_cmds.push_back(cmds[k]);
         end
      endfunction

      function int first_unwritten(int r);
         if (!rule_on[r]) return -1;
         for (int j = 0; j < rule_count[r]; j++) begin
            if (!written[r*ACTS+j]) return j;
         end
         return -1;
      endfunction

      task report(string msg);
         $display("ERROR at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_cmd(rsp_type got);
         rsp_type want;
         if (expected_cmds.size() == 0) begin
            report($sformatf("unexpected command %h", got));
            return;
         end
         want = expected_cmds.pop_front();
         if (got.out_rule != want.out_rule)
            report($sformatf("out_rule got %0d want %0d", got.out_rule, want.out_rule));
         if (got.out_loop != want.out_loop)
            report($sformatf("out_loop got %0d want %0d", got.out_loop, want.out_loop));
         if (got.out_dev != want.out_dev)
            report($sformatf("out_dev got %0d want %0d", got.out_dev, want.out_dev));
         if (got.out_channel != want.out_channel)
            report($sformatf("out_channel got %0d want %0d", got.out_channel, want.out_channel));
         if (got.out_start != want.out_start)
            report($sformatf("out_start got %0b want %0b", got.out_start, want.out_start));
         if (got.last != want.last)
            report($sformatf("last got %0b want %0b", got.last, want.last));
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   cmd_scoreboard sb;
   bit            no_gaps = 1'b0;
   int            items_sent = 0;
   int            cycle_count = 0;

   rule_linkage_action_sequencer #(
      .RULE_SLOTS(RULES),
      .ACTIONS_PER_RULE(ACTS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item)
   );

   always #2 clock = ~clock;

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function int pick_rule();
      if ($urandom_range(0, 3) != 0) return $urandom_range(0, 7);
      return $urandom_range(0, RULES - 1);
   endfunction

   function req_type noise_item();
      logic [63:0] bits;
      req_type     it;
      bits = {$urandom, $urandom};
      it = bits[$bits(req_type)-1:0];
      return it;
   endfunction

   function req_type eval_item(int r, bit cond, bit permit);
      req_type it;
      it = noise_item();
      it.func = FUNC_EVAL;
      it.rule_index = r[5:0];
      it.cond_ok = cond;
      it.exec_permit = permit;
      return it;
   endfunction

   function req_type hdr_item(int r, bit active, bit stop, bit [2:0] count);
      req_type it;
      it = noise_item();
      it.func = FUNC_HDR;
      it.rule_index = r[5:0];
      it.rule_active = active;
      it.stop_mode = stop;
      it.num_actions = count;
      return it;
   endfunction

   function req_type act_item(int r, bit [1:0] slot, bit [7:0] loop_no, bit [7:0] dev,
                              bit [7:0] chan, bit start);
      req_type it;
      it = noise_item();
      it.func = FUNC_ACT;
      it.rule_index = r[5:0];
      it.action_slot = slot;
      it.loop_no = loop_no;
      it.dev_no = dev;
      it.channel = chan;
      it.start_bit = start;
      return it;
   endfunction

   task send_item(req_type it);
      req_type item;
      int      slot;
      int      gap;
      item = it;
      // fill a missing action entry before the rule may read it
      if (item.func == FUNC_EVAL) begin
         slot = sb.first_unwritten(item.rule_index);
         if (slot >= 0)
            item = act_item(item.rule_index, slot[1:0], 8'($urandom), 8'($urandom),
                            8'($urandom), 1'($urandom));
      end
      req_item <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.apply_item(item);
      if (item.func != FUNC_NONE) items_sent++;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task run_sequence();
      int       r;
      int       cnt;
      int       reps;
      bit       stop;
      bit [7:0] chan;
      r = pick_rule();
      cnt = $urandom_range(0, 7);
      stop = ($urandom_range(0, 3) == 0);
      send_item(hdr_item(r, 1'b1, stop, cnt[2:0]));
      for (int j = 0; j < cnt && j < MAX_ACTS; j++) begin
         chan = ($urandom_range(0, 3) == 0) ? 8'd99 : 8'($urandom_range(0, 255));
         send_item(act_item(r, j[1:0], 8'($urandom), 8'($urandom), chan,
                            ($urandom_range(0, 3) != 0)));
      end
      send_item(eval_item(r, 1'b1, 1'b1));
      reps = $urandom_range(0, 2);
      repeat (reps) send_item(eval_item(r, 1'b1, 1'($urandom)));
      send_item(eval_item(r, 1'b0, 1'($urandom)));
      send_item(eval_item(r, 1'($urandom), 1'($urandom)));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_cmd(rsp_item);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int n;
      wait (!reset);
      forever begin
         n = $urandom_range(1, 40);
         rsp_stall <= 1'b0;
         repeat (n) @(posedge clock);
         n = pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   initial begin
      req_type it;
      int      sel;
      int      waited;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(eval_item(5, 1'b1, 1'b1));
      send_item(hdr_item(0, 1'b1, 1'b0, 3'd7));
      send_item(act_item(0, 2'd0, 8'd0, 8'd255, 8'd99, 1'b1));
      send_item(act_item(0, 2'd1, 8'd255, 8'd0, 8'd1, 1'b1));
      send_item(act_item(0, 2'd2, 8'd17, 8'd34, 8'd4, 1'b0));
      send_item(act_item(0, 2'd3, 8'd255, 8'd255, 8'd255, 1'b1));
      send_item(eval_item(0, 1'b1, 1'b0));
      send_item(eval_item(0, 1'b0, 1'b1));
      send_item(eval_item(0, 1'b1, 1'b1));
      send_item(eval_item(0, 1'b1, 1'b1));
      send_item(eval_item(0, 1'b0, 1'b0));
      send_item(eval_item(0, 1'b1, 1'b1));
      send_item(hdr_item(63, 1'b1, 1'b1, 3'd2));
      send_item(act_item(63, 2'd0, 8'd1, 8'd2, 8'd3, 1'b1));
      send_item(act_item(63, 2'd1, 8'd128, 8'd64, 8'd2, 1'b0));
      send_item(eval_item(63, 1'b1, 1'b1));
      send_item(eval_item(63, 1'b0, 1'b1));
      send_item(eval_item(63, 1'b0, 1'b0));
      it = noise_item();
      it.func = FUNC_NONE;
      it.rule_index = 6'd63;
      send_item(it);
      send_item(hdr_item(1, 1'b1, 1'b0, 3'd0));
      send_item(eval_item(1, 1'b1, 1'b1));
      send_item(eval_item(1, 1'b0, 1'b0));
      send_item(hdr_item(0, 1'b1, 1'b0, 3'd4));
      send_item(eval_item(0, 1'b1, 1'b1));
      send_item(hdr_item(0, 1'b0, 1'b0, 3'd4));
      send_item(eval_item(0, 1'b0, 1'b1));

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         no_gaps = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 99) < 55) begin
            run_sequence();
         end else begin
            it = noise_item();
            it.rule_index = 6'(pick_rule());
            sel = $urandom_range(0, 99);
            if (sel < 50) it.func = FUNC_EVAL;
            else if (sel < 70) it.func = FUNC_HDR;
            else if (sel < 90) it.func = FUNC_ACT;
            else it.func = FUNC_NONE;
            send_item(it);
         end
      end
      req_valid <= 1'b0;

      waited = 0;
      while (sb.expected_cmds.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.expected_cmds.size() != 0)
         sb.report($sformatf("%0d commands never arrived", sb.expected_cmds.size()));
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/rlas_pkg.sv
rtl/core/rule_linkage_action_sequencer.sv
bench/tb_top.sv
